### sv/sbrd_pkg.sv
// ----------------------------------------------------------------------------
// sbrd_pkg: shared types and codes for the backup record deframer
// beat payloads, parser state, role and status codes, header magic
// ----------------------------------------------------------------------------
package sbrd_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 16;
  localparam int ROLE_W   = 3;
  localparam int STATUS_W = 3;
  localparam int PHASE_W  = 3;
  localparam int HIDX_W   = 3;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BIG_ENDIAN = 1'd1;

  localparam logic [BYTE_W-1:0] VERSION_RESET = 8'd4;

  // parser phases
  localparam logic [PHASE_W-1:0] PH_HEADER      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_NAME_LEN    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_NAME        = 3'd2;
  localparam logic [PHASE_W-1:0] PH_VLEN_FIRST  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_VLEN_SECOND = 3'd4;
  localparam logic [PHASE_W-1:0] PH_VALUE       = 3'd5;
  localparam logic [PHASE_W-1:0] PH_IGNORE      = 3'd6;

  // byte roles
  localparam logic [ROLE_W-1:0] ROLE_HEADER   = 3'd0;
  localparam logic [ROLE_W-1:0] ROLE_NAME_LEN = 3'd1;
  localparam logic [ROLE_W-1:0] ROLE_NAME     = 3'd2;
  localparam logic [ROLE_W-1:0] ROLE_VLEN     = 3'd3;
  localparam logic [ROLE_W-1:0] ROLE_VALUE    = 3'd4;
  localparam logic [ROLE_W-1:0] ROLE_IGNORED  = 3'd5;

  // image status
  localparam logic [STATUS_W-1:0] ST_BUSY         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CLEAN        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SHORT_HEADER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_MAGIC    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_VERSION  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CUT_NAME     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CUT_LENGTH   = 3'd6;
  localparam logic [STATUS_W-1:0] ST_CUT_VALUE    = 3'd7;

  // header layout
  localparam logic [HIDX_W-1:0] HDR_COUNT_IDX   = 3'd6;
  localparam logic [HIDX_W-1:0] HDR_VERSION_IDX = 3'd7;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              final_byte;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic [ROLE_W-1:0]   byte_role;
    logic                name_end;
    logic                record_end;
    logic [BYTE_W-1:0]   saved_count;
    logic [LEN_W-1:0]    records_read;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] expected_version;
    logic              length_big_endian;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic [HIDX_W-1:0]   header_index;
    logic [LEN_W-1:0]    bytes_left;
    logic [BYTE_W-1:0]   length_first_byte;
    logic [BYTE_W-1:0]   header_count;
    logic [LEN_W-1:0]    record_total;
    logic [STATUS_W-1:0] final_status;
    logic                magic_bad;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '0;

  // six magic bytes at the start of the header
  function automatic logic [BYTE_W-1:0] magic_byte(input logic [HIDX_W-1:0] idx);
    logic [BYTE_W-1:0] m;
    case (idx)
      3'd0:    m = 8'h44;
      3'd1:    m = 8'h44;
      3'd2:    m = 8'h2D;
      3'd3:    m = 8'h57;
      3'd4:    m = 8'h52;
      3'd5:    m = 8'h54;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

### sv/sbrd_step.sv
// ----------------------------------------------------------------------------
// sbrd_step: one-byte parser step
// next parser state and tagged result for the byte in the input register
// ----------------------------------------------------------------------------
module sbrd_step import sbrd_pkg::*; (
  input  parse_state_t cur,
  input  cfg_t         cfg,
  input  item_t        item,
  output parse_state_t nxt,
  output result_t      res
);

  logic [BYTE_W-1:0]   b;
  logic                fin;
  logic [ROLE_W-1:0]   role;
  logic                ne;
  logic                re;
  logic [STATUS_W-1:0] st;
  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    left_dec;
  logic [LEN_W-1:0]    total_inc;

  assign b   = item.in_byte;
  assign fin = item.final_byte;
  assign len = cfg.length_big_endian ? {cur.length_first_byte, b}
                                     : {b, cur.length_first_byte};
  assign left_dec  = cur.bytes_left - 16'd1;
  // saturating record count
  assign total_inc = (cur.record_total == '1) ? cur.record_total
                                              : cur.record_total + 16'd1;

  always_comb begin
    nxt  = cur;
    role = ROLE_IGNORED;
    ne   = 1'b0;
    re   = 1'b0;
    st   = ST_BUSY;
    unique case (cur.phase)
      PH_HEADER: begin
        role = ROLE_HEADER;
        if (cur.header_index < HDR_COUNT_IDX && b != magic_byte(cur.header_index)) begin
          nxt.magic_bad = 1'b1;
        end
        if (cur.header_index == HDR_COUNT_IDX) begin
          nxt.header_count = b;
        end
        if (cur.header_index == HDR_VERSION_IDX) begin
          if (cur.magic_bad) begin
            st = ST_BAD_MAGIC;
          end else if (b != cfg.expected_version) begin
            st = ST_BAD_VERSION;
          end else begin
            nxt.phase = PH_NAME_LEN;
            if (fin) st = ST_CLEAN;
          end
        end else begin
          nxt.header_index = cur.header_index + 3'd1;
          if (fin) st = ST_SHORT_HEADER;
        end
      end
      PH_NAME_LEN: begin
        role = ROLE_NAME_LEN;
        nxt.bytes_left = {8'd0, b};
        if (b == '0) begin
          ne = 1'b1;
          nxt.phase = PH_VLEN_FIRST;
          if (fin) st = ST_CUT_LENGTH;
        end else begin
          nxt.phase = PH_NAME;
          if (fin) st = ST_CUT_NAME;
        end
      end
      PH_NAME: begin
        role = ROLE_NAME;
        nxt.bytes_left = left_dec;
        if (left_dec == '0) begin
          ne = 1'b1;
          nxt.phase = PH_VLEN_FIRST;
          if (fin) st = ST_CUT_LENGTH;
        end else if (fin) begin
          st = ST_CUT_NAME;
        end
      end
      PH_VLEN_FIRST: begin
        role = ROLE_VLEN;
        nxt.length_first_byte = b;
        nxt.phase = PH_VLEN_SECOND;
        if (fin) st = ST_CUT_LENGTH;
      end
      PH_VLEN_SECOND: begin
        role = ROLE_VLEN;
        nxt.bytes_left = len;
        if (len == '0) begin
          re = 1'b1;
          nxt.record_total = total_inc;
          nxt.phase = PH_NAME_LEN;
          if (fin) st = ST_CLEAN;
        end else begin
          nxt.phase = PH_VALUE;
          if (fin) st = ST_CUT_VALUE;
        end
      end
      PH_VALUE: begin
        role = ROLE_VALUE;
        nxt.bytes_left = left_dec;
        if (left_dec == '0) begin
          re = 1'b1;
          nxt.record_total = total_inc;
          nxt.phase = PH_NAME_LEN;
          if (fin) st = ST_CLEAN;
        end else if (fin) begin
          st = ST_CUT_VALUE;
        end
      end
      default: begin
        role = ROLE_IGNORED;
        st = cur.final_status;
      end
    endcase

    // latch the end status; park until the final flag if the image is not over
    if (st != ST_BUSY) begin
      nxt.final_status = st;
      if (!fin) nxt.phase = PH_IGNORE;
    end

    res.out_byte     = b;
    res.byte_role    = role;
    res.name_end     = ne;
    res.record_end   = re;
    res.saved_count  = nxt.header_count;
    res.records_read = nxt.record_total;
    res.status       = st;

    // final flag rearms the parser for the next image
    if (fin) nxt = STATE_RESET;
  end

endmodule

### sv/settings_backup_record_deframer_core.sv
// ----------------------------------------------------------------------------
// settings_backup_record_deframer_core: backup image byte parser
// path: a byte beat accepted into the input register is parsed into the result register
//   and can leave from there once result_stall is low
// throughput: one byte per cycle while result_stall is low, set by the single parser
//   step between the input register and the result register
// reset: synchronous rst clears parser state and the valid flags of both beat registers;
//   expected_version returns to 4 and length_big_endian to 0
// ----------------------------------------------------------------------------
module settings_backup_record_deframer_core import sbrd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // byte beats in
  input  logic                 item_valid,
  output logic                 item_stall,
  input  item_t                item,
  // tagged result beats out
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  // configuration registers
  cfg_t cfg;

  // input register
  logic  in_valid;
  item_t in_item;

  // parser state
  parse_state_t state;
  parse_state_t state_next;
  result_t      step_result;

  // handshake control
  logic advance;  // input register moves into the result register
  logic fire;     // a byte is parsed this cycle

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version  <= VERSION_RESET;
      cfg.length_big_endian <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EXPECTED_VERSION:  cfg.expected_version  <= cfg_data;
        CFG_LENGTH_BIG_ENDIAN: cfg.length_big_endian <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // result register is free when empty or its beat is taken this cycle
  assign advance    = !result_valid || !result_stall;
  assign fire       = in_valid && advance;
  // input register takes a new beat whenever it is empty or moving on
  assign item_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!item_stall) begin
      in_valid <= item_valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      in_item <= item;
    end
  end

  sbrd_step u_step (
    .cur  (state),
    .cfg  (cfg),
    .item (in_item),
    .nxt  (state_next),
    .res  (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= step_result;
    end
  end

  // a stall toward the byte source only comes from a held input beat
  assert property (@(posedge clk) disable iff (rst) item_stall |-> in_valid && result_valid)
    else $error("input stalled without a blocked result");

  // a final byte always rearms the parser with a cleared record count
  assert property (@(posedge clk) disable iff (rst)
    fire && in_item.final_byte |=> state.phase == PH_HEADER && state.record_total == '0
      && state.final_status == ST_BUSY)
    else $error("parser not rearmed after final byte");

  // a record can only complete on a value length or value byte
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.record_end |->
      result.byte_role == ROLE_VLEN || result.byte_role == ROLE_VALUE)
    else $error("record end on a byte of the wrong role");

  // while parked after an error, results carry the ignored role and no flags
  assert property (@(posedge clk) disable iff (rst)
    fire && state.phase == PH_IGNORE |=>
      result.byte_role == ROLE_IGNORED && !result.name_end && !result.record_end)
    else $error("parked parser produced a tagged byte");

endmodule

### test/sbrd_tb_pkg.sv
// ----------------------------------------------------------------------------
// sbrd_tb_pkg: byte parser predictor and result scoreboard
// keeps its own copy of the register settings and parser state, works out
// the tagged result of every accepted byte beat and checks result beats in order
// ----------------------------------------------------------------------------
package sbrd_tb_pkg;
  import sbrd_pkg::*;

  localparam int unsigned MAGIC_LEN = 6;
  localparam logic [47:0] HDR_MAGIC = 48'h44_44_2D_57_52_54;

  function automatic logic [BYTE_W-1:0] magic_at(input int unsigned idx);
    return HDR_MAGIC[47 - 8*idx -: 8];
  endfunction

  class deframer_scoreboard;
    logic [BYTE_W-1:0] version;
    logic              big_endian;
    parse_state_t      ps;
    result_t           tagged_q[$];
    int unsigned       mismatches;

    function new();
      version    = VERSION_RESET;
      big_endian = 1'b0;
      ps         = STATE_RESET;
      mismatches = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
      case (idx)
        CFG_EXPECTED_VERSION:  version = data;
        CFG_LENGTH_BIG_ENDIAN: big_endian = data[0];
        default: ;
      endcase
    endfunction

    function void bump_records();
      if (ps.record_total != '1) ps.record_total++;
    endfunction

    function result_t parse_byte(input item_t it);
      result_t             r;
      logic [STATUS_W-1:0] stv;
      logic [LEN_W-1:0]    vlen;
      logic [BYTE_W-1:0]   b;
      logic                last;
      r = '0;
      b = it.in_byte;
      last = it.final_byte;
      r.out_byte = b;
      r.byte_role = ROLE_IGNORED;
      stv = ST_BUSY;
      case (ps.phase)
        PH_HEADER: begin
          r.byte_role = ROLE_HEADER;
          if (ps.header_index < MAGIC_LEN && b != magic_at(ps.header_index)) ps.magic_bad = 1'b1;
          if (ps.header_index == HDR_COUNT_IDX) ps.header_count = b;
          if (ps.header_index == HDR_VERSION_IDX) begin
            // bad magic wins over bad version
            if (ps.magic_bad) stv = ST_BAD_MAGIC;
            else if (b != version) stv = ST_BAD_VERSION;
            else begin
              ps.phase = PH_NAME_LEN;
              if (last) stv = ST_CLEAN;
            end
          end else begin
            ps.header_index++;
            if (last) stv = ST_SHORT_HEADER;
          end
        end
        PH_NAME_LEN: begin
          r.byte_role = ROLE_NAME_LEN;
          ps.bytes_left = {8'h00, b};
          if (b == 8'h00) begin
            r.name_end = 1'b1;
            ps.phase = PH_VLEN_FIRST;
            if (last) stv = ST_CUT_LENGTH;
          end else begin
            ps.phase = PH_NAME;
            if (last) stv = ST_CUT_NAME;
          end
        end
        PH_NAME: begin
          r.byte_role = ROLE_NAME;
          ps.bytes_left--;
          if (ps.bytes_left == '0) begin
            r.name_end = 1'b1;
            ps.phase = PH_VLEN_FIRST;
            if (last) stv = ST_CUT_LENGTH;
          end else if (last) begin
            stv = ST_CUT_NAME;
          end
        end
        PH_VLEN_FIRST: begin
          r.byte_role = ROLE_VLEN;
          ps.length_first_byte = b;
          ps.phase = PH_VLEN_SECOND;
          if (last) stv = ST_CUT_LENGTH;
        end
        PH_VLEN_SECOND: begin
          r.byte_role = ROLE_VLEN;
          vlen = big_endian ? {ps.length_first_byte, b} : {b, ps.length_first_byte};
          ps.bytes_left = vlen;
          if (vlen == '0) begin
            r.record_end = 1'b1;
            bump_records();
            ps.phase = PH_NAME_LEN;
            if (last) stv = ST_CLEAN;
          end else begin
            ps.phase = PH_VALUE;
            if (last) stv = ST_CUT_VALUE;
          end
        end
        PH_VALUE: begin
          r.byte_role = ROLE_VALUE;
          ps.bytes_left--;
          if (ps.bytes_left == '0) begin
            r.record_end = 1'b1;
            bump_records();
            ps.phase = PH_NAME_LEN;
            if (last) stv = ST_CLEAN;
          end else if (last) begin
            stv = ST_CUT_VALUE;
          end
        end
        default: stv = ps.final_status;
      endcase
      if (stv != ST_BUSY) begin
        ps.final_status = stv;
        if (!last) ps.phase = PH_IGNORE;
      end
      r.saved_count = ps.header_count;
      r.records_read = ps.record_total;
      r.status = stv;
      if (last) ps = STATE_RESET;
      return r;
    endfunction

    function void note_byte(input item_t it);
      tagged_q.push_back(parse_byte(it));
    endfunction

    function void report(input string field, input int unsigned want, input int unsigned got);
      mismatches++;
      if (mismatches <= 10) $display("%s: expected %0h, got %0h", field, want, got);
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (tagged_q.size() == 0) begin
        report("result beat with nothing pending", 0, 32'(got.out_byte));
        return;
      end
      want = tagged_q.pop_front();
      if (got.out_byte     !== want.out_byte)     report("out_byte", want.out_byte, got.out_byte);
      if (got.byte_role    !== want.byte_role)    report("byte_role", want.byte_role, got.byte_role);
      if (got.name_end     !== want.name_end)     report("name_end", want.name_end, got.name_end);
      if (got.record_end   !== want.record_end)
        report("record_end", want.record_end, got.record_end);
      if (got.saved_count  !== want.saved_count)
        report("saved_count", want.saved_count, got.saved_count);
      if (got.records_read !== want.records_read)
        report("records_read", want.records_read, got.records_read);
      if (got.status       !== want.status)       report("status", want.status, got.status);
    endfunction

    function int unsigned pending();
      return tagged_q.size();
    endfunction
  endclass

endpackage

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for settings_backup_record_deframer_core
// feeds backup images byte by byte (good images, cut images, bad headers and
// noise) under several register settings and random idling on both sides,
// and checks every tagged result beat against an in-order prediction
// ----------------------------------------------------------------------------
module tb_top;
  import sbrd_pkg::*;
  import sbrd_tb_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  deframer_scoreboard sb;

  // idling percentages for each side, and the long receiver hold-off
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned stall_hold_left = 0;
  bit          stall_hold_req = 1'b0;

  // image under construction and the settings it is built for
  logic [7:0]  image_bytes[$];
  logic [7:0]  cur_version = VERSION_RESET;
  logic        cur_big_endian = 1'b0;

  settings_backup_record_deframer_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor: both channels sampled at the rising edge, before any register update
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_byte(item);
      if (result_valid && !result_stall) sb.check_result(result);
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk);
      if (stall_hold_req) begin
        stall_hold_left = 120;
        stall_hold_req = 1'b0;
      end
      if (stall_hold_left > 0) begin
        result_stall = 1'b1;
        stall_hold_left--;
      end else begin
        result_stall = (receiver_idle_pct != 0) && ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  // one byte beat; valid stays up and the payload holds until accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item.in_byte = b;
    item.final_byte = last;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  // last byte of the image carries the final flag
  task automatic send_image();
    for (int i = 0; i < image_bytes.size(); i++)
      send_byte(image_bytes[i], i == image_bytes.size() - 1);
  endtask

  // every byte gives one result, so idle means nothing pending
  task automatic wait_idle();
    @(negedge clk);
    item_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // first two settings are the extremes, later ones random
  task automatic change_settings(input int unsigned n);
    logic [7:0] ver;
    logic       big;
    wait_idle();
    if (n == 0) begin
      ver = 8'h00;
      big = 1'b1;
    end else if (n == 1) begin
      ver = 8'hFF;
      big = 1'b0;
    end else begin
      case ($urandom_range(3))
        0:       ver = 8'h00;
        1:       ver = 8'hFF;
        2:       ver = VERSION_RESET;
        default: ver = 8'($urandom_range(255));
      endcase
      big = 1'($urandom_range(1));
    end
    write_cfg(CFG_EXPECTED_VERSION, ver);
    // upper data bits are junk for the one-bit register
    write_cfg(CFG_LENGTH_BIG_ENDIAN, {7'($urandom_range(127)), big});
    cur_version = ver;
    cur_big_endian = big;
  endtask

  function automatic void put_header(input logic [7:0] count, input logic [7:0] ver);
    image_bytes.delete();
    for (int i = 0; i < MAGIC_LEN; i++) image_bytes.push_back(magic_at(i));
    image_bytes.push_back(count);
    image_bytes.push_back(ver);
  endfunction

  // record bytes stop at cap so a huge value length stays cheap
  function automatic void put_record(input int unsigned name_len, input int unsigned value_len,
                                     input int unsigned cap);
    logic [15:0] vl;
    vl = 16'(value_len);
    image_bytes.push_back(8'(name_len));
    for (int i = 0; i < name_len && image_bytes.size() < cap; i++)
      image_bytes.push_back(8'($urandom_range(255)));
    if (cur_big_endian) begin
      image_bytes.push_back(vl[15:8]);
      image_bytes.push_back(vl[7:0]);
    end else begin
      image_bytes.push_back(vl[7:0]);
      image_bytes.push_back(vl[15:8]);
    end
    for (int i = 0; i < value_len && image_bytes.size() < cap; i++)
      image_bytes.push_back(8'($urandom_range(255)));
  endfunction

  function automatic int unsigned pick_name_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 80) return $urandom_range(4);
    if (p < 95) return $urandom_range(20, 5);
    return $urandom_range(255);
  endfunction

  function automatic int unsigned pick_value_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 80) return $urandom_range(6);
    if (p < 93) return $urandom_range(64, 7);
    if (p < 97) return $urandom_range(300, 200);
    return $urandom_range(65535);
  endfunction

  function automatic void cut_image(input int unsigned keep);
    while (image_bytes.size() > keep) void'(image_bytes.pop_back());
  endfunction

  // mostly well-formed images with random content, some cut short,
  // the rest bad headers, short headers and noise
  function automatic void random_image();
    int unsigned kind;
    int unsigned n;
    int unsigned pos;
    kind = $urandom_range(99);
    put_header(8'($urandom_range(255)), cur_version);
    if (kind < 55) begin
      n = $urandom_range(4);
      for (int i = 0; i < n && image_bytes.size() < 160; i++)
        put_record(pick_name_len(), pick_value_len(), 160);
      if (image_bytes.size() >= 160 || $urandom_range(99) < 35)
        cut_image($urandom_range(image_bytes.size(), 1));
    end else if (kind < 75) begin
      // bad magic, bad version or both, then bytes that must be ignored
      pos = $urandom_range(MAGIC_LEN - 1);
      case ($urandom_range(2))
        0: image_bytes[pos] = image_bytes[pos] ^ 8'($urandom_range(255, 1));
        1: image_bytes[7] = image_bytes[7] ^ 8'($urandom_range(255, 1));
        default: begin
          image_bytes[pos] = image_bytes[pos] ^ 8'($urandom_range(255, 1));
          image_bytes[7] = image_bytes[7] ^ 8'($urandom_range(255, 1));
        end
      endcase
      n = $urandom_range(6);
      for (int i = 0; i < n; i++) image_bytes.push_back(8'($urandom_range(255)));
    end else if (kind < 85) begin
      cut_image($urandom_range(7, 1));
    end else begin
      image_bytes.delete();
      n = $urandom_range(16, 1);
      for (int i = 0; i < n; i++) image_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  initial begin
    int unsigned random_bytes;
    int unsigned images;
    int unsigned settings;
    bit          pressure_done;
    random_bytes = 0;
    images = 0;
    settings = 0;
    pressure_done = 1'b0;
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset settings: header only image ends clean with no records
    put_header(8'hFF, VERSION_RESET);
    send_image();
    // empty name and empty value in one record
    put_header(8'h00, VERSION_RESET);
    repeat (3) image_bytes.push_back(8'h00);
    send_image();
    // short header
    image_bytes.delete();
    image_bytes.push_back(8'h44);
    image_bytes.push_back(8'h00);
    image_bytes.push_back(8'hFF);
    send_image();

    // random images in three idling regimes
    while (random_bytes < 650) begin
      if (random_bytes < 217) begin
        sender_idle_pct = 21;
        receiver_idle_pct = 80;
      end else if (random_bytes < 433) begin
        sender_idle_pct = 80;
        receiver_idle_pct = 21;
      end else begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      if (images % 6 == 0) begin
        change_settings(settings);
        settings++;
      end
      // long receiver hold-off while bytes keep coming, fills the block up
      if (!pressure_done && random_bytes >= 433) begin
        stall_hold_req = 1'b1;
        pressure_done = 1'b1;
      end
      random_image();
      send_image();
      random_bytes += image_bytes.size();
      images++;
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("settings_backup_record_deframer_core: match");
    end else begin
      $display("settings_backup_record_deframer_core: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #20000000;
    $display("settings_backup_record_deframer_core: mismatch");
    $finish;
  end

endmodule

### settings_backup_record_deframer_core.f
sv/sbrd_pkg.sv
sv/sbrd_step.sv
sv/settings_backup_record_deframer_core.sv
test/sbrd_tb_pkg.sv
test/tb_top.sv
